// ===== sv/wav_pcm16_stream_writer_assert.svh =====
// assertion macros shared by the checker of the wav pcm16 stream writer
// no dependencies
`ifndef WAV_PCM16_STREAM_WRITER_ASSERT_SVH
`define WAV_PCM16_STREAM_WRITER_ASSERT_SVH
// property that must hold at each edge outside reset
`define WAV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked through reset as well
`define WAV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== sv/wavw_pkg.sv =====
// package of the wav pcm16 stream writer: shared constants and conversion types
// no dependencies
`default_nettype none
package wavw_pkg;
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;
  localparam int unsigned HDR_LEN = 44;
  localparam logic [1:0] REG_NUM_CHANNELS = 2'd0;
  localparam logic [1:0] REG_SAMPLE_RATE = 2'd1;
  localparam logic [1:0] REG_FRAMES = 2'd2;

  // conversion pipeline payload between stages
  typedef struct packed {
    logic        is_nan;
    logic        neg;
    logic        clamp;
    logic        is_zero;
    logic [7:0]  exp;
    logic [23:0] mant;
  } cvt_s1_t;
endpackage
`default_nettype wire

// ===== sv/wavw_pcm_conv.sv =====
// float to pcm16 conversion pipeline, three register stages with stall
// depends on wavw_pkg
`default_nettype none
module wavw_pcm_conv (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [31:0] in_bits,
  input  wire logic        advance,
  output logic             out_valid,
  output logic [15:0]      out_pcm
);
  wavw_pkg::cvt_s1_t s1;
  logic              v1, v2, v3;
  logic [40:0]       prod;
  logic [7:0]        exp2;
  logic              neg2, zero2, clamp2, nan2;
  logic [15:0]       pcm3;
  logic [71:0]       shifted;
  logic [15:0]       mag;
  logic [40:0]       raw;
  logic [40:0]       rnd;
  logic              hi;
  logic [23:0]       kept;
  logic              guard;
  logic              sticky;
  logic              inc;
  logic [24:0]       sum25;

  // stage 1: decode fields
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      s1.is_nan  <= (in_bits[30:23] == 8'hff) && (in_bits[22:0] != 23'd0);
      s1.neg     <= in_bits[31];
      s1.clamp   <= in_bits[30:23] >= 8'd127;
      s1.is_zero <= in_bits[30:23] == 8'd0;
      s1.exp     <= in_bits[30:23];
      s1.mant    <= {1'b1, in_bits[22:0]};
    end
  end

  // positive scale: mant * 32767 rounded to 24 significant bits, nearest even
  always_comb begin
    raw    = {2'd0, s1.mant, 15'd0} - {17'd0, s1.mant};
    hi     = raw[38];
    kept   = hi ? raw[38:15] : raw[37:14];
    guard  = hi ? raw[14] : raw[13];
    sticky = hi ? (|raw[13:0]) : (|raw[12:0]);
    inc    = guard && (sticky || kept[0]);
    sum25  = {1'b0, kept} + {24'd0, inc};
    rnd    = hi ? {1'b0, sum25, 15'd0} : {2'd0, sum25, 14'd0};
  end

  // stage 2: scaled significand, single precision rounding on the positive side
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      prod   <= s1.neg ? {2'd0, s1.mant, 15'd0} : rnd;
      exp2   <= s1.exp;
      neg2   <= s1.neg;
      zero2  <= s1.is_zero;
      clamp2 <= s1.clamp;
      nan2   <= s1.is_nan;
    end
  end

  // integer part of prod * 2^(exp - 150), below exponent 104 it is zero
  always_comb begin
    shifted = {31'd0, prod} << exp2[4:0];
    mag     = (exp2 < 8'd104) ? 16'd0 : shifted[69:54];
  end

  // stage 3: align, clamp, sign
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      if (nan2 || zero2) begin
        pcm3 <= 16'd0;
      end else if (clamp2) begin
        pcm3 <= neg2 ? 16'h8000 : 16'h7fff;
      end else begin
        pcm3 <= neg2 ? (16'd0 - mag) : mag;
      end
    end
  end

  assign out_valid = v3;
  assign out_pcm   = pcm3;
endmodule
`default_nettype wire

// ===== sv/wav_pcm16_stream_writer.sv =====
// wav pcm16 stream writer top level: apb registers, input pipeline, byte serializer
// depends on wavw_pkg and wavw_pcm_conv
//
// usage: s_tdata carries sample_bits, s_tuser carries op (0 header, 1 sample).
// a header beat yields a 44-byte run of the canonical wav header, a sample
// beat yields two bytes (low, high) of the clamped, scaled pcm16 value.
// m_tdata is the byte, m_tlast marks the final byte of each run.
// path: a beat passes three pipeline stages, then the serializer head register
// holds it while its bytes go out on the byte-wide output.
// the pipeline accepts a beat each cycle while the serializer head is free or is
// giving out its last byte, and holds everything while m_tready is low without
// loss or repeat.
// reset: registers return to 2 channels, 48000 hz, 0 frames; pipeline empties.
// the user writes configuration through the apb port only while the block is idle;
// the block itself does not enforce this.
`default_nettype none
module wav_pcm16_stream_writer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // sample_bits[31:0]
  input  wire logic        s_tuser,  // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // out_byte[7:0]
  output logic             m_tlast,  // last
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [3:0]  num_channels;
  logic [18:0] sample_rate;
  logic [26:0] frames_per_channel;
  logic [1:0]  reg_idx;
  logic        wr_en;

  // apb register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && (paddr[1:0] == 2'd0);
  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels       <= 4'd2;
      sample_rate        <= 19'd48000;
      frames_per_channel <= 27'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        wavw_pkg::REG_NUM_CHANNELS: num_channels       <= pwdata[3:0];
        wavw_pkg::REG_SAMPLE_RATE:  sample_rate        <= pwdata[18:0];
        wavw_pkg::REG_FRAMES:       frames_per_channel <= pwdata[26:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'd0) begin
      unique case (reg_idx)
        wavw_pkg::REG_NUM_CHANNELS: prdata = {28'd0, num_channels};
        wavw_pkg::REG_SAMPLE_RATE:  prdata = {13'd0, sample_rate};
        wavw_pkg::REG_FRAMES:       prdata = {5'd0, frames_per_channel};
        default:                    prdata = 32'd0;
      endcase
    end
  end

  // derived header fields; user must change registers only while idle, not enforced
  logic [4:0]  align;
  logic [31:0] dsize, brate;
  always_ff @(posedge clk) begin
    align <= {num_channels, 1'b0};
    dsize <= {27'd0, num_channels, 1'b0} * {5'd0, frames_per_channel};
    brate <= {27'd0, num_channels, 1'b0} * {13'd0, sample_rate};
  end

  // pipeline with op tag beside the converter
  logic       advance, head_busy, head_take;
  logic       cv_valid;
  logic [15:0] cv_pcm;
  logic [2:0] op_pipe;
  assign advance  = !head_busy || head_take;
  assign s_tready = advance;

  wavw_pcm_conv u_conv (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid && s_tready), .in_bits(s_tdata),
    .advance(advance), .out_valid(cv_valid), .out_pcm(cv_pcm)
  );
  always_ff @(posedge clk) begin
    if (advance) begin
      op_pipe <= {op_pipe[1:0], s_tuser};
    end
  end

  // serializer head: holds one item and walks its bytes
  logic        h_op;
  logic [15:0] h_pcm;
  logic [5:0]  cnt;
  logic        h_last;
  assign h_last    = h_op ? (cnt == 6'd1) : (cnt == 6'(wavw_pkg::HDR_LEN - 1));
  assign head_take = head_busy && m_tready && h_last;
  always_ff @(posedge clk) begin
    if (rst) begin
      head_busy <= 1'b0;
    end else begin
      if (advance) begin
        head_busy <= cv_valid;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      h_op  <= op_pipe[2];
      h_pcm <= cv_pcm;
      cnt   <= 6'd0;
    end else if (head_busy && m_tready) begin
      cnt <= cnt + 6'd1;
    end
  end

  // header byte lookup
  logic [7:0]  hb;
  logic [31:0] rsize;
  assign rsize = dsize + 32'd36;
  always_comb begin
    case (cnt)
      6'd0: hb = 8'h52;  6'd1: hb = 8'h49;  6'd2: hb = 8'h46;  6'd3: hb = 8'h46;
      6'd4: hb = rsize[7:0];   6'd5: hb = rsize[15:8];
      6'd6: hb = rsize[23:16]; 6'd7: hb = rsize[31:24];
      6'd8: hb = 8'h57;  6'd9: hb = 8'h41;  6'd10: hb = 8'h56; 6'd11: hb = 8'h45;
      6'd12: hb = 8'h66; 6'd13: hb = 8'h6d; 6'd14: hb = 8'h74; 6'd15: hb = 8'h20;
      6'd16: hb = 8'd16;
      6'd20: hb = 8'd1;
      6'd22: hb = {4'd0, num_channels};
      6'd24: hb = sample_rate[7:0];  6'd25: hb = sample_rate[15:8];
      6'd26: hb = {5'd0, sample_rate[18:16]};
      6'd28: hb = brate[7:0];   6'd29: hb = brate[15:8];
      6'd30: hb = brate[23:16]; 6'd31: hb = brate[31:24];
      6'd32: hb = {3'd0, align};
      6'd34: hb = 8'd16;
      6'd36: hb = 8'h64; 6'd37: hb = 8'h61; 6'd38: hb = 8'h74; 6'd39: hb = 8'h61;
      6'd40: hb = dsize[7:0];   6'd41: hb = dsize[15:8];
      6'd42: hb = dsize[23:16]; 6'd43: hb = dsize[31:24];
      default: hb = 8'd0;
    endcase
  end

  assign m_tvalid = head_busy;
  assign m_tlast  = h_last;
  assign m_tdata  = (h_op == wavw_pkg::OP_SAMPLE) ?
                    (cnt[0] ? h_pcm[15:8] : h_pcm[7:0]) : hb;
endmodule
`default_nettype wire

// ===== sv/wavw_checker.sv =====
// port-level checker for the wav pcm16 stream writer, bound to the top level
// depends on wav_pcm16_stream_writer_assert.svh
`include "wav_pcm16_stream_writer_assert.svh"
`default_nettype none
module wavw_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       pready
);
  `WAV_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output dropped")
  `WAV_ASSERT(a_stall_blocks, m_tvalid && !m_tready |-> !s_tready, "input taken during stall")
  `WAV_ASSERT_ALWAYS(a_pready, pready, "pready low")
  `WAV_ASSERT(a_last_hold, m_tvalid && !m_tready |=> $stable(m_tlast), "last changed in stall")
endmodule
bind wav_pcm16_stream_writer wavw_checker u_chk (.*);
`default_nettype wire
